@@ src/point_in_cone_test_defines.svh @@
// assertion macros for the point-in-cone test block
`ifndef POINT_IN_CONE_TEST_DEFINES_SVH
`define POINT_IN_CONE_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising clock edge outside reset
`define PIC_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PIC_ASSERT_SAME(name, ante, cons, msg)
`define PIC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

@@ src/pic_pkg.sv @@
// shared constants and types for the point-in-cone test block
package pic_pkg;

   localparam int unsigned COORD_WIDTH_DEF = 16;
   // limb width of the split multipliers, keeps each partial product at 24 x 24
   localparam int unsigned LIMB_WIDTH = 24;
   // register stages through one split multiplier
   localparam int unsigned MUL_LAT = 3;

   typedef struct packed {
      logic nc_zero;
      logic np_zero;
      logic s1_neg;
      logic s2_neg;
      logic d1_zero;
   } flags_type;

endpackage

@@ src/pic_req_if.sv @@
// request channel carrying the four points of one cone query
interface pic_req_if #(
   parameter int unsigned COORD_W = pic_pkg::COORD_WIDTH_DEF
);
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] apex_x;
   logic signed [COORD_W-1:0] apex_y;
   logic signed [COORD_W-1:0] apex_z;
   logic signed [COORD_W-1:0] axis_x;
   logic signed [COORD_W-1:0] axis_y;
   logic signed [COORD_W-1:0] axis_z;
   logic signed [COORD_W-1:0] rim_x;
   logic signed [COORD_W-1:0] rim_y;
   logic signed [COORD_W-1:0] rim_z;
   logic signed [COORD_W-1:0] query_x;
   logic signed [COORD_W-1:0] query_y;
   logic signed [COORD_W-1:0] query_z;

   modport source (
      output valid,
      input  ready,
      output apex_x, apex_y, apex_z,
      output axis_x, axis_y, axis_z,
      output rim_x, rim_y, rim_z,
      output query_x, query_y, query_z
   );

   modport sink (
      input  valid,
      output ready,
      input  apex_x, apex_y, apex_z,
      input  axis_x, axis_y, axis_z,
      input  rim_x, rim_y, rim_z,
      input  query_x, query_y, query_z
   );
endinterface

@@ src/pic_rsp_if.sv @@
// response channel carrying the inside flag of one cone query
interface pic_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (
      output valid,
      input  ready,
      output inside_res
   );

   modport sink (
      input  valid,
      output ready,
      input  inside_res
   );
endinterface

@@ src/pic_umul.sv @@
// pipelined unsigned multiplier built from limb partial products
module pic_umul #(
   parameter int unsigned A_W    = 34,
   parameter int unsigned B_W    = 34,
   parameter int unsigned LIMB_W = pic_pkg::LIMB_WIDTH
) (
   input  logic               clock,
   input  logic               en,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p
);
   localparam int unsigned NA  = (A_W + LIMB_W - 1) / LIMB_W;
   localparam int unsigned NB  = (B_W + LIMB_W - 1) / LIMB_W;
   localparam int unsigned APW = NA * LIMB_W;
   localparam int unsigned BPW = NB * LIMB_W;
   localparam int unsigned RW  = (NB + 1) * LIMB_W;
   localparam int unsigned TW  = (NA + NB) * LIMB_W;

   logic [APW-1:0]        a_pad;
   logic [BPW-1:0]        b_pad;
   logic [2*LIMB_W-1:0]   pp_ff  [NA][NB];
   logic [RW-1:0]         even_c [NA];
   logic [RW-1:0]         odd_c  [NA];
   logic [RW-1:0]         row_ff [NA];
   logic [TW-1:0]         sum_in;
   logic [TW-1:0]         sum_ff;

   assign a_pad = APW'(a);
   assign b_pad = BPW'(b);

   // even and odd limb products of a row do not overlap, so they just concatenate
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         even_c[i] = '0;
         odd_c[i]  = '0;
         for (int j = 0; j < NB; j++) begin
            if ((j % 2) == 0) begin
               even_c[i][j*LIMB_W +: 2*LIMB_W] = pp_ff[i][j];
            end else begin
               odd_c[i][j*LIMB_W +: 2*LIMB_W] = pp_ff[i][j];
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         sum_in = sum_in + (TW'(row_ff[i]) << (i * LIMB_W));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= a_pad[i*LIMB_W +: LIMB_W] * b_pad[j*LIMB_W +: LIMB_W];
            end
            row_ff[i] <= even_c[i] + odd_c[i];
         end
         sum_ff <= sum_in;
      end
   end

   assign p = sum_ff[A_W+B_W-1:0];

endmodule

@@ src/point_in_cone_test.sv @@
// point-in-cone test: exact integer angle compare, fully pipelined
// pipeline: 4 front stages, two split multipliers of 3 stages each, one output register
// throughput: one query per cycle; every stage holds when the response stalls
// reset: synchronous, clears the stage valid bits only; data registers are not reset
`include "point_in_cone_test_defines.svh"

module point_in_cone_test #(
   parameter int unsigned COORD_WIDTH = pic_pkg::COORD_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   pic_req_if.sink   req_if,
   pic_rsp_if.source rsp_if
);
   import pic_pkg::*;

   localparam int unsigned DW     = COORD_WIDTH + 1;
   localparam int unsigned PW     = 2 * DW;
   localparam int unsigned SW     = PW + 1;
   localparam int unsigned MW     = SW - 1;
   localparam int unsigned QW     = 2 * MW;
   localparam int unsigned FW     = 3 * MW;
   localparam int unsigned FDEPTH = 2 * MUL_LAT + 1;
   localparam int unsigned STAGES = 4 + FDEPTH;

   logic                          en;
   logic                          accept;
   logic [STAGES-1:0]             vld_ff;
   logic [STAGES-1:0]             vld_in;

   logic signed [COORD_WIDTH-1:0] apex_c  [3];
   logic signed [COORD_WIDTH-1:0] axis_c  [3];
   logic signed [COORD_WIDTH-1:0] rim_c   [3];
   logic signed [COORD_WIDTH-1:0] query_c [3];

   logic signed [DW-1:0]          ab_ff  [3];
   logic signed [DW-1:0]          ac_ff  [3];
   logic signed [DW-1:0]          ap_ff  [3];
   logic signed [PW-1:0]          d1p_ff [3];
   logic signed [PW-1:0]          d2p_ff [3];
   logic signed [PW-1:0]          ncp_ff [3];
   logic signed [PW-1:0]          npp_ff [3];
   logic signed [SW-1:0]          d1_ff;
   logic signed [SW-1:0]          d2_ff;
   logic signed [SW-1:0]          nc_ff;
   logic signed [SW-1:0]          np_ff;

   logic [MW-1:0]                 m1_in;
   logic [MW-1:0]                 m2_in;
   logic [MW-1:0]                 m1_ff;
   logic [MW-1:0]                 m2_ff;
   logic [MW-1:0]                 ncm_ff;
   logic [MW-1:0]                 npm_ff;
   logic [MW-1:0]                 ncd_ff [MUL_LAT];
   logic [MW-1:0]                 npd_ff [MUL_LAT];
   flags_type                     flg_in;
   flags_type                     flg_ff [FDEPTH];
   flags_type                     fl_out;

   logic [QW-1:0]                 sq1;
   logic [QW-1:0]                 sq2;
   logic [FW-1:0]                 lhs;
   logic [FW-1:0]                 rhs;
   logic                          inside_in;
   logic                          inside_ff;

   // the whole pipeline advances unless the output holds an untaken result
   assign en           = !vld_ff[STAGES-1] || rsp_if.ready;
   assign req_if.ready = en && !reset;
   assign accept       = req_if.valid && req_if.ready;
   assign vld_in       = {vld_ff[STAGES-2:0], accept};

   assign apex_c[0]  = req_if.apex_x;
   assign apex_c[1]  = req_if.apex_y;
   assign apex_c[2]  = req_if.apex_z;
   assign axis_c[0]  = req_if.axis_x;
   assign axis_c[1]  = req_if.axis_y;
   assign axis_c[2]  = req_if.axis_z;
   assign rim_c[0]   = req_if.rim_x;
   assign rim_c[1]   = req_if.rim_y;
   assign rim_c[2]   = req_if.rim_z;
   assign query_c[0] = req_if.query_x;
   assign query_c[1] = req_if.query_y;
   assign query_c[2] = req_if.query_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // dot products are nonnegative-magnitude split from their signs here
   always_comb begin
      m1_in          = d1_ff[SW-1] ? MW'(-d1_ff) : MW'(d1_ff);
      m2_in          = d2_ff[SW-1] ? MW'(-d2_ff) : MW'(d2_ff);
      flg_in.nc_zero = (nc_ff == '0);
      flg_in.np_zero = (np_ff == '0);
      flg_in.s1_neg  = d1_ff[SW-1];
      flg_in.s2_neg  = d2_ff[SW-1];
      flg_in.d1_zero = (d1_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i]  <= DW'(axis_c[i]) - DW'(apex_c[i]);
            ac_ff[i]  <= DW'(rim_c[i]) - DW'(apex_c[i]);
            ap_ff[i]  <= DW'(query_c[i]) - DW'(apex_c[i]);
            d1p_ff[i] <= ab_ff[i] * ac_ff[i];
            d2p_ff[i] <= ab_ff[i] * ap_ff[i];
            ncp_ff[i] <= ac_ff[i] * ac_ff[i];
            npp_ff[i] <= ap_ff[i] * ap_ff[i];
         end
         d1_ff     <= SW'(d1p_ff[0]) + SW'(d1p_ff[1]) + SW'(d1p_ff[2]);
         d2_ff     <= SW'(d2p_ff[0]) + SW'(d2p_ff[1]) + SW'(d2p_ff[2]);
         nc_ff     <= SW'(ncp_ff[0]) + SW'(ncp_ff[1]) + SW'(ncp_ff[2]);
         np_ff     <= SW'(npp_ff[0]) + SW'(npp_ff[1]) + SW'(npp_ff[2]);
         m1_ff     <= m1_in;
         m2_ff     <= m2_in;
         ncm_ff    <= MW'(nc_ff);
         npm_ff    <= MW'(np_ff);
         ncd_ff[0] <= ncm_ff;
         npd_ff[0] <= npm_ff;
         for (int k = 1; k < MUL_LAT; k++) begin
            ncd_ff[k] <= ncd_ff[k-1];
            npd_ff[k] <= npd_ff[k-1];
         end
         flg_ff[0] <= flg_in;
         for (int k = 1; k < FDEPTH; k++) begin
            flg_ff[k] <= flg_ff[k-1];
         end
         inside_ff <= inside_in;
      end
   end

   // squares of the dot magnitudes
   pic_umul #(
      .A_W    (MW),
      .B_W    (MW),
      .LIMB_W (LIMB_WIDTH)
   ) u_sq1 (
      .clock (clock),
      .en    (en),
      .a     (m1_ff),
      .b     (m1_ff),
      .p     (sq1)
   );

   pic_umul #(
      .A_W    (MW),
      .B_W    (MW),
      .LIMB_W (LIMB_WIDTH)
   ) u_sq2 (
      .clock (clock),
      .en    (en),
      .a     (m2_ff),
      .b     (m2_ff),
      .p     (sq2)
   );

   // cross scaling by the other vector's squared length
   pic_umul #(
      .A_W    (MW),
      .B_W    (QW),
      .LIMB_W (LIMB_WIDTH)
   ) u_lhs (
      .clock (clock),
      .en    (en),
      .a     (npd_ff[MUL_LAT-1]),
      .b     (sq1),
      .p     (lhs)
   );

   pic_umul #(
      .A_W    (MW),
      .B_W    (QW),
      .LIMB_W (LIMB_WIDTH)
   ) u_rhs (
      .clock (clock),
      .en    (en),
      .a     (ncd_ff[MUL_LAT-1]),
      .b     (sq2),
      .p     (rhs)
   );

   assign fl_out = flg_ff[FDEPTH-1];

   // zero-length rim or query handled first, else signed compare of d1*|d1|*np against d2*|d2|*nc
   always_comb begin
      if (fl_out.nc_zero) begin
         inside_in = !fl_out.s2_neg;
      end else if (fl_out.np_zero) begin
         inside_in = fl_out.s1_neg || fl_out.d1_zero;
      end else if (fl_out.s1_neg != fl_out.s2_neg) begin
         inside_in = fl_out.s1_neg;
      end else if (fl_out.s1_neg) begin
         inside_in = (lhs >= rhs);
      end else begin
         inside_in = (lhs <= rhs);
      end
   end

   assign rsp_if.valid      = vld_ff[STAGES-1];
   assign rsp_if.inside_res = inside_ff;

   `PIC_ASSERT_SAME(a_ready_when_empty, !rsp_if.valid && !reset, req_if.ready,
      "ready low with empty output")
   `PIC_ASSERT_NEXT(a_entry_valid, req_if.valid && req_if.ready && !reset, vld_ff[0],
      "transfer lost at entry")
   `PIC_ASSERT_NEXT(a_zero_rim, en && vld_ff[STAGES-2] && fl_out.nc_zero && !reset,
      rsp_if.valid && (rsp_if.inside_res == !$past(fl_out.s2_neg)),
      "zero rim vector result wrong")

endmodule
